/* rtl/multi_channel_sine_servo_oscillator_macros.svh */
`ifndef MULTI_CHANNEL_SINE_SERVO_OSCILLATOR_MACROS_SVH
`define MULTI_CHANNEL_SINE_SERVO_OSCILLATOR_MACROS_SVH

// Same-cycle implication on the rising clock edge, off while reset is asserted
`define MCSO_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mcso: same-cycle check failed");

// Next-cycle implication on the rising clock edge, off while reset is asserted
`define MCSO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mcso: next-cycle check failed");

`endif

/* rtl/mcso_pkg.sv */
package mcso_pkg;

	// Channel count and channel field width
	localparam int NUM_CHANNELS = 4;
	localparam int CH_BITS = 2;

	// Phase accumulator and sine table geometry
	localparam int PHASE_BITS = 16;
	localparam int SINE_TABLE_DEPTH = 256;
	localparam int TAB_IDX_BITS = $clog2(SINE_TABLE_DEPTH);
	localparam int SINE_HALF = 2 * SINE_TABLE_DEPTH;

	// Period and sample interval widths
	localparam int PER_BITS = 16;
	localparam int SAMPLE_BITS = 10;

	// Divider geometry: the increment numerator is 2^PHASE_BITS + n/2
	localparam int DIV_W = (PHASE_BITS + 1 > PER_BITS) ? PHASE_BITS + 1 : PER_BITS;
	localparam int DIV_STEPS = (DIV_W + 1) / 2;
	localparam int NUM_W = 2 * DIV_STEPS;
	localparam int CNT_W = $clog2(DIV_STEPS + 1);
	localparam logic [DIV_W-1:0] INC_NUM = DIV_W'(1) << PHASE_BITS;

	// Pi in Q30
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	// Register map, one 64-bit slot per register
	typedef enum logic [2:0] {
		REG_AMPLITUDES    = 3'd0,
		REG_OFFSETS       = 3'd1,
		REG_PERIODS       = 3'd2,
		REG_PHASE_OFFSETS = 3'd3,
		REG_REVERSE       = 3'd4,
		REG_STOP          = 3'd5,
		REG_SAMPLE_MS     = 3'd6,
		REG_TRIMS         = 3'd7
	} reg_idx_t;

	typedef logic [PHASE_BITS-1:0] phase_t;
	typedef logic signed [15:0] sine_t;
	typedef sine_t sine_tab_t [SINE_TABLE_DEPTH];

	// Per-channel state word kept in the state memory
	typedef struct packed {
		logic [31:0] last_ms;
		phase_t      phase;
	} chan_state_t;

	// Request into the position pipeline
	typedef struct packed {
		logic        start;
		phase_t      phase;
		logic [15:0] phase_off;
		logic [7:0]  amp;
		logic [7:0]  offset;
		logic [7:0]  trim;
		logic        reverse;
	} pos_req_t;

	// Result from the position pipeline
	typedef struct packed {
		logic       done;
		logic [7:0] position;
	} pos_res_t;

	// Divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// One table entry: sin(2*pi*k/D) in Q1.15 through a Q30 Taylor series
	function automatic sine_t sine_entry(int unsigned k);
		logic [63:0] a;
		logic [63:0] th;
		logic [63:0] th2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] q;
		logic        neg;
		a = 64'(4 * k);
		neg = 1'b0;
		if (a >= 64'(SINE_HALF)) begin
			neg = 1'b1;
			a = a - 64'(SINE_HALF);
		end
		if (a > 64'(SINE_TABLE_DEPTH)) a = 64'(SINE_HALF) - a;
		th = (a * PI_Q30) / SINE_HALF;
		th2 = (th * th) >> 30;
		term = th;
		sum = th;
		term = ((term * th2) >> 30) / 6;   sum = sum - term;
		term = ((term * th2) >> 30) / 20;  sum = sum + term;
		term = ((term * th2) >> 30) / 42;  sum = sum - term;
		term = ((term * th2) >> 30) / 72;  sum = sum + term;
		term = ((term * th2) >> 30) / 110; sum = sum - term;
		term = ((term * th2) >> 30) / 156; sum = sum + term;
		term = ((term * th2) >> 30) / 210; sum = sum - term;
		term = ((term * th2) >> 30) / 272; sum = sum + term;
		q = (sum + 64'd16384) >> 15;
		if (q > 64'd32767) q = 64'd32767;
		return neg ? -sine_t'(q[15:0]) : sine_t'(q[15:0]);
	endfunction

	function automatic sine_tab_t sine_table_init();
		sine_tab_t t;
		int unsigned k;
		for (k = 0; k < SINE_TABLE_DEPTH; k++) t[k] = sine_entry(k);
		return t;
	endfunction

	localparam sine_tab_t SINE_TAB = sine_table_init();

	// Scale a 16-bit fraction of a turn to the accumulator width, truncating
	function automatic phase_t scale_phase_off(logic [15:0] ph);
		logic [PHASE_BITS+15:0] w;
		w = (PHASE_BITS + 16)'(ph) << PHASE_BITS;
		return phase_t'(w >> 16);
	endfunction

endpackage

/* rtl/mcso_state_mem.sv */
module mcso_state_mem import mcso_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [CH_BITS-1:0]  rd_addr,
	output chan_state_t         rd_data,
	input  logic                wr_en,
	input  logic [CH_BITS-1:0]  wr_addr,
	input  chan_state_t         wr_data
);

	chan_state_t            mem_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] valid_q;
	chan_state_t            rd_data_q;
	logic                   rd_valid_q;

	// Mark entries as written; an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) valid_q[wr_addr] <= 1'b1;
			if (rd_en) rd_valid_q <= valid_q[rd_addr];
		end
	end

	// Write the entry and register the read data
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

/* rtl/mcso_divider.sv */
module mcso_divider import mcso_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIV_W-1:0]    dividend,
	input  logic [PER_BITS-1:0] divisor,
	output div_stat_t           stat,
	output logic [DIV_W-1:0]    quotient
);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [NUM_W-1:0]    num_q;
	logic [PER_BITS-1:0] rem_q;
	logic [PER_BITS-1:0] den_q;

	logic [PER_BITS:0]   part0;
	logic [PER_BITS:0]   part1;
	logic                ge0;
	logic                ge1;
	logic [PER_BITS-1:0] rem0;
	logic [PER_BITS-1:0] rem1;
	logic [NUM_W-1:0]    num0;
	logic [NUM_W-1:0]    num1;

	// Two restoring steps per cycle, quotient bits shift into the dividend word
	always_comb begin
		part0 = {rem_q, num_q[NUM_W-1]};
		ge0 = part0 >= {1'b0, den_q};
		rem0 = ge0 ? PER_BITS'(part0 - {1'b0, den_q}) : part0[PER_BITS-1:0];
		num0 = {num_q[NUM_W-2:0], ge0};
		part1 = {rem0, num0[NUM_W-1]};
		ge1 = part1 >= {1'b0, den_q};
		rem1 = ge1 ? PER_BITS'(part1 - {1'b0, den_q}) : part1[PER_BITS-1:0];
		num1 = {num0[NUM_W-2:0], ge1};
	end

	// Count the iterations and flag completion for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Load the operands, then advance the partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= NUM_W'(dividend);
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= num1;
			rem_q <= rem1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient = num_q[DIV_W-1:0];

endmodule

/* rtl/mcso_pos_calc.sv */
module mcso_pos_calc import mcso_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  pos_req_t req,
	output pos_res_t res
);

	phase_t                   lookup_phase;
	logic [TAB_IDX_BITS-1:0]  lookup_idx;

	logic                     vld_s1;
	logic                     vld_s2;
	logic                     vld_s3;
	logic                     vld_s4;
	sine_t                    sine_s1;
	logic [7:0]               amp_s1;
	logic signed [7:0]        off_s1;
	logic signed [7:0]        trim_s1;
	logic                     rev_s1;
	logic signed [24:0]       prod_s2;
	logic signed [7:0]        off_s2;
	logic signed [7:0]        trim_s2;
	logic                     rev_s2;
	logic signed [11:0]       drive_s3;
	logic [7:0]               position_s4;

	logic [24:0]              mag;
	logic [8:0]               rmag;
	logic signed [9:0]        rnd;
	logic signed [10:0]       pos;
	logic signed [10:0]       pos_dir;
	logic signed [11:0]       drive;
	logic [11:0]              scaled;
	logic [23:0]              recip;
	logic [7:0]               position;

	// Add the phase offset and pick the table entry
	always_comb begin
		lookup_phase = req.phase + scale_phase_off(req.phase_off);
		lookup_idx = lookup_phase[PHASE_BITS-1 -: TAB_IDX_BITS];
	end

	// Round the amplitude product, apply offset, direction, center and trim
	always_comb begin
		mag = prod_s2[24] ? 25'(-prod_s2) : 25'(prod_s2);
		rmag = 9'((mag + 25'd16384) >> 15);
		rnd = prod_s2[24] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
		pos = 11'(rnd) + 11'(off_s2);
		pos_dir = rev_s2 ? -pos : pos;
		drive = 12'(pos_dir) + 12'sd90 + 12'(trim_s2);
	end

	// Scale degrees by 255/180 = 17/12, saturating to a byte
	always_comb begin
		scaled = 12'(drive_s3[7:0]) * 12'd17;
		recip = 24'(scaled) * 24'd2731;
		if (drive_s3 < 0) position = 8'd0;
		else if (drive_s3 >= 12'sd180) position = 8'd255;
		else position = recip[22:15];
	end

	// Advance the stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= req.start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Stage data
	always_ff @(posedge clk) begin
		sine_s1 <= SINE_TAB[lookup_idx];
		amp_s1 <= req.amp;
		off_s1 <= $signed(req.offset);
		trim_s1 <= $signed(req.trim);
		rev_s1 <= req.reverse;
		prod_s2 <= $signed({1'b0, amp_s1}) * sine_s1;
		off_s2 <= off_s1;
		trim_s2 <= trim_s1;
		rev_s2 <= rev_s1;
		drive_s3 <= drive;
		position_s4 <= position;
	end

	assign res.done = vld_s4;
	assign res.position = position_s4;

endmodule

/* rtl/multi_channel_sine_servo_oscillator.sv */
// Four-channel sine oscillator for servos. Each input transaction names a channel and the
// current millisecond count; when more than sample_ms milliseconds have passed since that
// channel's last sample, the block records the new sample time, emits one position byte on
// the output channel (unless the channel is stopped) and advances the channel's phase by one
// turn divided by (period / sample_ms). Per-channel phase and last-sample time live in a small
// state memory with a registered read that resets to zero through per-entry valid bits, so no
// clearing pass is needed after reset. A transaction whose sample is not due goes from ST_IDLE
// through ST_CHECK back to ST_IDLE and produces nothing. Each due sample is worked through by
// the shared two-bit-per-cycle divider, which first forms the step count
// and then the phase increment; one transaction is worked on at a time. Position output is
// registered, so a finished result may wait for out_ready while the next transaction is
// taken. Registers sit at byte address 8*i on a 64-bit APB-style port, pready is always high.
`include "multi_channel_sine_servo_oscillator_macros.svh"

module multi_channel_sine_servo_oscillator import mcso_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// input channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CH_BITS-1:0]  channel,
	input  logic [31:0]         now_ms,
	// output channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CH_BITS-1:0]  out_channel,
	output logic [7:0]          position,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [5:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV_N,
		ST_DIV_INC,
		ST_WB,
		ST_DELIVER
	} fsm_state_t;

	// Configuration registers
	logic [31:0]            amplitudes_q;
	logic [31:0]            offsets_q;
	logic [63:0]            periods_q;
	logic [63:0]            phase_offsets_q;
	logic [3:0]             reverse_q;
	logic [3:0]             stop_q;
	logic [SAMPLE_BITS-1:0] sample_ms_q;
	logic [31:0]            trims_q;

	// Sequencer state and transaction registers
	fsm_state_t             state_q;
	logic [CH_BITS-1:0]     channel_q;
	logic [31:0]            now_q;
	phase_t                 phase_q;
	phase_t                 inc_q;
	logic                   emit_q;
	logic                   pos_ready_q;
	logic [7:0]             pos_q;
	logic                   out_valid_q;
	logic [CH_BITS-1:0]     out_channel_q;
	logic [7:0]             position_q;

	logic                   cfg_wr;
	reg_idx_t               reg_idx;
	chan_state_t            mem_rd;
	chan_state_t            mem_wr;
	logic                   mem_rd_en;
	logic                   mem_wr_en;
	logic                   due;
	logic                   n_zero;
	logic [PER_BITS-1:0]    per_sel;
	logic [PER_BITS-1:0]    sample_div;
	logic                   div_start;
	logic [DIV_W-1:0]       div_dividend;
	logic [PER_BITS-1:0]    div_divisor;
	logic [DIV_W-1:0]       div_quo;
	div_stat_t              div_stat;
	pos_req_t               pos_req;
	pos_res_t               pos_res;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[5:3]);

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitudes_q <= 32'h2D2D_2D2D;
			offsets_q <= '0;
			periods_q <= 64'h07D0_07D0_07D0_07D0;
			phase_offsets_q <= '0;
			reverse_q <= '0;
			stop_q <= '0;
			sample_ms_q <= SAMPLE_BITS'(30);
			trims_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_AMPLITUDES:    amplitudes_q <= pwdata[31:0];
				REG_OFFSETS:       offsets_q <= pwdata[31:0];
				REG_PERIODS:       periods_q <= pwdata;
				REG_PHASE_OFFSETS: phase_offsets_q <= pwdata;
				REG_REVERSE:       reverse_q <= pwdata[3:0];
				REG_STOP:          stop_q <= pwdata[3:0];
				REG_SAMPLE_MS:     sample_ms_q <= pwdata[SAMPLE_BITS-1:0];
				REG_TRIMS:         trims_q <= pwdata[31:0];
				default:           ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (reg_idx)
			REG_AMPLITUDES:    prdata = 64'(amplitudes_q);
			REG_OFFSETS:       prdata = 64'(offsets_q);
			REG_PERIODS:       prdata = periods_q;
			REG_PHASE_OFFSETS: prdata = phase_offsets_q;
			REG_REVERSE:       prdata = 64'(reverse_q);
			REG_STOP:          prdata = 64'(stop_q);
			REG_SAMPLE_MS:     prdata = 64'(sample_ms_q);
			REG_TRIMS:         prdata = 64'(trims_q);
			default:           prdata = '0;
		endcase
	end

	// State memory: read on accept, write back once the increment is known
	assign mem_rd_en = in_valid && in_ready;
	assign mem_wr_en = (state_q == ST_WB);
	assign mem_wr.last_ms = now_q;
	assign mem_wr.phase = phase_q + inc_q;

	mcso_state_mem u_state_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_rd_en),
		.rd_addr (channel),
		.rd_data (mem_rd),
		.wr_en   (mem_wr_en),
		.wr_addr (channel_q),
		.wr_data (mem_wr)
	);

	// Sample due test and per-channel field selection
	always_comb begin
		due = (now_q - mem_rd.last_ms) > 32'(sample_ms_q);
		per_sel = periods_q[16*channel_q +: 16];
		sample_div = (sample_ms_q == '0) ? PER_BITS'(1) : PER_BITS'(sample_ms_q);
		n_zero = (div_quo[PER_BITS-1:0] == '0);
	end

	// Divider requests: step count first, then the rounded phase increment
	always_comb begin
		div_start = 1'b0;
		div_dividend = DIV_W'(per_sel);
		div_divisor = sample_div;
		case (state_q)
			ST_CHECK: div_start = due;
			ST_DIV_N: begin
				div_start = div_stat.done && !n_zero;
				div_dividend = INC_NUM + DIV_W'(div_quo[PER_BITS-1:1]);
				div_divisor = div_quo[PER_BITS-1:0];
			end
			default: ;
		endcase
	end

	mcso_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// Position request from the memory read and the channel's registers
	always_comb begin
		pos_req.start = (state_q == ST_CHECK) && due && !stop_q[channel_q];
		pos_req.phase = mem_rd.phase;
		pos_req.phase_off = phase_offsets_q[16*channel_q +: 16];
		pos_req.amp = amplitudes_q[8*channel_q +: 8];
		pos_req.offset = offsets_q[8*channel_q +: 8];
		pos_req.trim = trims_q[8*channel_q +: 8];
		pos_req.reverse = reverse_q[channel_q];
	end

	mcso_pos_calc u_pos_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (pos_req),
		.res    (pos_res)
	);

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			channel_q <= '0;
			now_q <= '0;
			phase_q <= '0;
			inc_q <= '0;
			emit_q <= 1'b0;
			pos_ready_q <= 1'b0;
			pos_q <= '0;
			out_valid_q <= 1'b0;
			out_channel_q <= '0;
			position_q <= '0;
		end else begin
			// drop the result once the consumer takes it, unless a new one replaces it
			if (out_valid_q && out_ready && state_q != ST_DELIVER) out_valid_q <= 1'b0;
			// hold the finished position until delivery
			if (pos_res.done) begin
				pos_ready_q <= 1'b1;
				pos_q <= pos_res.position;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						channel_q <= channel;
						now_q <= now_ms;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (due) begin
						phase_q <= mem_rd.phase;
						emit_q <= !stop_q[channel_q];
						state_q <= ST_DIV_N;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV_N: begin
					if (div_stat.done) begin
						if (n_zero) begin
							inc_q <= '0;
							state_q <= ST_WB;
						end else begin
							state_q <= ST_DIV_INC;
						end
					end
				end
				ST_DIV_INC: begin
					if (div_stat.done) begin
						inc_q <= div_quo[PHASE_BITS-1:0];
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					state_q <= emit_q ? ST_DELIVER : ST_IDLE;
				end
				ST_DELIVER: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_channel_q <= channel_q;
						position_q <= pos_q;
						pos_ready_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_channel = out_channel_q;
	assign position = position_q;

	// An accepted transaction sees its state word in the next cycle
	`MCSO_ASSERT_NEXT(a_accept_to_check, clk, arst_n, in_valid && in_ready, state_q == ST_CHECK)
	// The position pipeline finishes before the divider chain
	`MCSO_ASSERT_SAME(a_pos_ready_at_deliver, clk, arst_n, state_q == ST_DELIVER, pos_ready_q)
	// The shared divider is never restarted mid-division
	`MCSO_ASSERT_SAME(a_div_free_on_start, clk, arst_n, div_start, !div_stat.busy)

endmodule
